// ===== rtl/core/stoi_pkg.sv =====
// Package for the string-to-integer parser: parse phase codes, character
// codes, the parse control struct and the digit/whitespace decoders.
// No dependencies.
`default_nettype none

package stoi_pkg;

   localparam int PHASE_BITS = 3;
   localparam int BASE_BITS  = 6;
   localparam int CHAR_BITS  = 8;
   localparam int DIGIT_BITS = 7;

   // widths of the result fields on the output beat
   localparam int VALUE_BITS   = 32;
   localparam int ENDPOS_BITS  = 16;
   localparam int RSP_DATA_BITS = 56;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - VALUE_BITS - ENDPOS_BITS - 1;

   // parse phases
   localparam logic [PHASE_BITS-1:0] PH_SPACE  = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_START  = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_ZERO   = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_XSEEN  = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_DONE   = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_DIGITS = 3'd5;

   // register indexes on the csr port
   localparam logic CSR_BASE   = 1'b0;
   localparam logic CSR_SIGNED = 1'b1;

   localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_ONE  = 6'd1;
   localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
   localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;

   localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SP    = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
   localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
   localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;

   localparam logic [DIGIT_BITS-1:0] NO_DIGIT = 7'd99;
   localparam logic [DIGIT_BITS-1:0] ALPHA_OFFSET = 7'd10;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic [BASE_BITS-1:0]  base;
      logic                  negative;
      logic                  overflow;
   } ctrl_type;

   function automatic logic [DIGIT_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c);
      logic [DIGIT_BITS-1:0] v;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = DIGIT_BITS'(c - CH_ZERO);
      end else if (c >= CH_LA && c <= CH_LZ) begin
         v = DIGIT_BITS'(c - CH_LA) + ALPHA_OFFSET;
      end else if (c >= CH_UA && c <= CH_UZ) begin
         v = DIGIT_BITS'(c - CH_UA) + ALPHA_OFFSET;
      end else begin
         v = NO_DIGIT;
      end
      return v;
   endfunction

   function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
      return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stoi_step.sv =====
// Next parse state for one non-terminator character: whitespace and sign,
// base prefix handling, and the accumulator multiply-add with carry check.
// Depends on stoi_pkg.
`default_nettype none

module stoi_step #(
   parameter int WORD_BITS = 32,
   parameter int POS_BITS  = 16,
   parameter logic [POS_BITS-1:0] POS_LIMIT = '1
) (
   input  wire logic [stoi_pkg::CHAR_BITS-1:0] char_code,
   input  wire logic [stoi_pkg::BASE_BITS-1:0] base_setting,
   input  wire stoi_pkg::ctrl_type             ctrl_cur,
   input  wire logic [WORD_BITS-1:0]           acc_cur,
   input  wire logic [POS_BITS-1:0]            pos_cur,
   input  wire logic [POS_BITS-1:0]            dend_cur,
   output stoi_pkg::ctrl_type                  ctrl_nxt,
   output logic [WORD_BITS-1:0]                acc_nxt,
   output logic [POS_BITS-1:0]                 pos_nxt,
   output logic [POS_BITS-1:0]                 dend_nxt
);

   localparam int PROD_BITS = WORD_BITS + stoi_pkg::BASE_BITS;

   logic [stoi_pkg::BASE_BITS-1:0]  setting_base;
   logic [stoi_pkg::BASE_BITS-1:0]  digit_base;
   logic [stoi_pkg::DIGIT_BITS-1:0] dval;
   logic [PROD_BITS-1:0]            prod;
   logic                            start;
   logic                            take;
   logic                            mark;

   assign dval = stoi_pkg::digit_value(char_code);

   always_comb begin
      setting_base = base_setting;
      if (base_setting == stoi_pkg::BASE_ONE || base_setting > stoi_pkg::BASE_MAX) begin
         setting_base = stoi_pkg::BASE_MAX;
      end

      ctrl_nxt   = ctrl_cur;
      acc_nxt    = acc_cur;
      dend_nxt   = dend_cur;
      start      = 1'b0;
      take       = 1'b0;
      mark       = 1'b0;
      digit_base = stoi_pkg::BASE_MAX;
      prod       = '0;

      case (ctrl_cur.phase)
         stoi_pkg::PH_SPACE: begin
            if (stoi_pkg::is_space(char_code)) begin
               ctrl_nxt.phase = stoi_pkg::PH_SPACE;
            end else if (char_code == stoi_pkg::CH_PLUS || char_code == stoi_pkg::CH_MINUS) begin
               ctrl_nxt.negative = (char_code == stoi_pkg::CH_MINUS);
               ctrl_nxt.phase    = stoi_pkg::PH_START;
            end else begin
               start = 1'b1;
            end
         end
         stoi_pkg::PH_START: begin
            start = 1'b1;
         end
         stoi_pkg::PH_ZERO: begin
            if (char_code == stoi_pkg::CH_LX || char_code == stoi_pkg::CH_UX) begin
               ctrl_nxt.phase = stoi_pkg::PH_XSEEN;
            end else begin
               ctrl_nxt.base  = (ctrl_cur.base == stoi_pkg::BASE_AUTO) ?
                                stoi_pkg::BASE_OCT : stoi_pkg::BASE_HEX;
               ctrl_nxt.phase = stoi_pkg::PH_DIGITS;
               take           = 1'b1;
            end
         end
         stoi_pkg::PH_XSEEN: begin
            if (dval < stoi_pkg::DIGIT_BITS'(stoi_pkg::BASE_HEX)) begin
               ctrl_nxt.base  = stoi_pkg::BASE_HEX;
               ctrl_nxt.phase = stoi_pkg::PH_DIGITS;
               take           = 1'b1;
            end else begin
               // "0x" with no hex digit after it: only the zero counts
               ctrl_nxt.base  = (ctrl_cur.base == stoi_pkg::BASE_AUTO) ?
                                stoi_pkg::BASE_OCT : stoi_pkg::BASE_HEX;
               ctrl_nxt.phase = stoi_pkg::PH_DONE;
            end
         end
         stoi_pkg::PH_DIGITS: begin
            take = 1'b1;
         end
         default: begin
            ctrl_nxt.phase = stoi_pkg::PH_DONE;
         end
      endcase

      if (start) begin
         if (char_code == stoi_pkg::CH_ZERO &&
             (setting_base == stoi_pkg::BASE_AUTO || setting_base == stoi_pkg::BASE_HEX)) begin
            ctrl_nxt.base  = setting_base;
            acc_nxt        = '0;
            mark           = 1'b1;
            ctrl_nxt.phase = stoi_pkg::PH_ZERO;
         end else begin
            ctrl_nxt.base  = (setting_base == stoi_pkg::BASE_AUTO) ?
                             stoi_pkg::BASE_DEC : setting_base;
            ctrl_nxt.phase = stoi_pkg::PH_DIGITS;
            take           = 1'b1;
         end
      end

      if (take) begin
         digit_base = ctrl_nxt.base;
         if (ctrl_nxt.base < 6'd2 || ctrl_nxt.base > stoi_pkg::BASE_MAX) begin
            digit_base = stoi_pkg::BASE_MAX;
         end
         if (dval >= stoi_pkg::DIGIT_BITS'(digit_base)) begin
            ctrl_nxt.phase = stoi_pkg::PH_DONE;
         end else begin
            // acc * base + digit; any bit above the word means overflow
            prod = PROD_BITS'(acc_cur) * PROD_BITS'(digit_base) + PROD_BITS'(dval);
            if (!ctrl_cur.overflow) begin
               if (prod[PROD_BITS-1:WORD_BITS] != '0) begin
                  ctrl_nxt.overflow = 1'b1;
               end else begin
                  acc_nxt = prod[WORD_BITS-1:0];
               end
            end
            mark = 1'b1;
         end
      end

      if (mark) begin
         dend_nxt = (pos_cur == POS_LIMIT) ? POS_LIMIT : pos_cur + POS_BITS'(1);
      end

      pos_nxt = (pos_cur < POS_LIMIT) ? pos_cur + POS_BITS'(1) : pos_cur;
   end

endmodule

`default_nettype wire

// ===== rtl/core/string_to_integer_parser_unit.sv =====
// String-to-integer parser (strtol / strtoul rules), top level.
// Depends on stoi_pkg and stoi_step.
//
// One character enters per beat on req_, a zero byte ends the string and
// yields one result beat on rsp_ carrying value, end position and range
// error; other characters yield nothing. The unit sustains one character per
// clock unless a terminator waits on a stalled result: each beat is first held
// in the input register, then the parse state and result registers update. The
// single multiply-add of the accumulator by the base sets the cycle time. A
// stalled result holds back only a terminator, but the characters behind it
// wait in turn. Write the csr registers only while idle.
`default_nettype none

module string_to_integer_parser_unit #(
   parameter int                WORD_BITS      = 32,
   parameter longint unsigned   POSITION_LIMIT = 65535
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // config write port
   input  wire logic                                csr_we,
   input  wire logic                                csr_index,
   input  wire logic [stoi_pkg::BASE_BITS-1:0]      csr_wdata,
   // input beat
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [stoi_pkg::CHAR_BITS-1:0]      req_tdata,   // [7:0] char_code
   // result beat
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [stoi_pkg::RSP_DATA_BITS-1:0]       rsp_tdata    // [31:0] value,
                                                                 // [47:32] end_position,
                                                                 // [48] range_error
);

   localparam int POS_BITS = $clog2(POSITION_LIMIT + 64'd1);
   localparam logic [POS_BITS-1:0] POS_LIMIT = POS_BITS'(POSITION_LIMIT);

   logic [stoi_pkg::BASE_BITS-1:0] base_ff, base_in;
   logic                           signed_ff, signed_in;

   logic                           in_valid_ff, in_valid_in;
   logic [stoi_pkg::CHAR_BITS-1:0] in_char_ff, in_char_in;

   stoi_pkg::ctrl_type             ctrl_ff, ctrl_in, ctrl_step;
   logic [WORD_BITS-1:0]           acc_ff, acc_in, acc_step;
   logic [POS_BITS-1:0]            pos_ff, pos_in, pos_step;
   logic [POS_BITS-1:0]            dend_ff, dend_in, dend_step;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [stoi_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                 is_term;
   logic                 fire;
   logic [WORD_BITS-1:0] smax;
   logic [WORD_BITS-1:0] smin;
   logic [WORD_BITS-1:0] neg_acc;
   logic [WORD_BITS-1:0] result;
   logic                 range_err;

   stoi_step #(
      .WORD_BITS (WORD_BITS),
      .POS_BITS  (POS_BITS),
      .POS_LIMIT (POS_LIMIT)
   ) u_step (
      .char_code    (in_char_ff),
      .base_setting (base_ff),
      .ctrl_cur     (ctrl_ff),
      .acc_cur      (acc_ff),
      .pos_cur      (pos_ff),
      .dend_cur     (dend_ff),
      .ctrl_nxt     (ctrl_step),
      .acc_nxt      (acc_step),
      .pos_nxt      (pos_step),
      .dend_nxt     (dend_step)
   );

   assign is_term = (in_char_ff == stoi_pkg::CH_NUL);
   // only a terminator needs room in the result register
   assign fire       = in_valid_ff && (!is_term || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // final value with strtol / strtoul saturation
   always_comb begin
      smax      = {1'b0, {(WORD_BITS-1){1'b1}}};
      smin      = {1'b1, {(WORD_BITS-1){1'b0}}};
      neg_acc   = ~acc_ff + WORD_BITS'(1);
      range_err = 1'b0;
      result    = acc_ff;
      if (signed_ff) begin
         if (ctrl_ff.overflow) begin
            range_err = 1'b1;
            result    = ctrl_ff.negative ? smin : smax;
         end else if (ctrl_ff.negative) begin
            if (acc_ff > smin) begin
               range_err = 1'b1;
               result    = smin;
            end else begin
               result = neg_acc;
            end
         end else if (acc_ff > smax) begin
            range_err = 1'b1;
            result    = smax;
         end
      end else begin
         if (ctrl_ff.overflow) begin
            range_err = 1'b1;
            result    = '1;
         end else if (ctrl_ff.negative) begin
            result = neg_acc;
         end
      end
   end

   always_comb begin
      base_in   = base_ff;
      signed_in = signed_ff;
      if (csr_we) begin
         case (csr_index)
            stoi_pkg::CSR_BASE:   base_in   = csr_wdata;
            stoi_pkg::CSR_SIGNED: signed_in = csr_wdata[0];
            default:              base_in   = base_ff;
         endcase
      end

      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_char_in  = req_tdata;
      end

      ctrl_in      = ctrl_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      dend_in      = dend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         if (is_term) begin
            ctrl_in.phase    = stoi_pkg::PH_SPACE;
            ctrl_in.base     = stoi_pkg::BASE_AUTO;
            ctrl_in.negative = 1'b0;
            ctrl_in.overflow = 1'b0;
            acc_in           = '0;
            pos_in           = '0;
            dend_in          = '0;
            rsp_valid_in     = 1'b1;
            rsp_data_in      = {{stoi_pkg::RSP_PAD_BITS{1'b0}}, range_err,
                                stoi_pkg::ENDPOS_BITS'(dend_ff),
                                stoi_pkg::VALUE_BITS'(result)};
         end else begin
            ctrl_in = ctrl_step;
            acc_in  = acc_step;
            pos_in  = pos_step;
            dend_in = dend_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff          <= stoi_pkg::BASE_DEC;
         signed_ff        <= 1'b1;
         in_valid_ff      <= 1'b0;
         ctrl_ff.phase    <= stoi_pkg::PH_SPACE;
         ctrl_ff.base     <= stoi_pkg::BASE_AUTO;
         ctrl_ff.negative <= 1'b0;
         ctrl_ff.overflow <= 1'b0;
         acc_ff           <= '0;
         pos_ff           <= '0;
         dend_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         base_ff      <= base_in;
         signed_ff    <= signed_in;
         in_valid_ff  <= in_valid_in;
         ctrl_ff      <= ctrl_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         dend_ff      <= dend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== tb/tb_string_to_integer_parser_unit.sv =====
// Self-checking testbench for string_to_integer_parser_unit: directed strings, then
// random strings under random config, with random idling on both sides.
// Depends on stoi_pkg and the parser RTL.

module tb_string_to_integer_parser_unit;
   import stoi_pkg::*;

   localparam int DRAIN_CYCLES  = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_CHARS  = 360;
   localparam int HOLD_CYCLES   = 120;
   localparam int NUM_ROWS      = 27;
   localparam longint unsigned WORD_MASK = 64'hFFFF_FFFF;

   typedef struct packed {
      bit [31:0] value;
      bit [15:0] end_pos;
      bit        range_err;
   } parse_result_type;

   typedef struct packed {
      bit [5:0]  base;
      bit        sgn;
      bit        known;
      bit [31:0] value;
      bit [15:0] end_pos;
      bit        range_err;
   } case_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = CSR_BASE;
   logic [BASE_BITS-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [CHAR_BITS-1:0] req_tdata = '0;   // [7:0] char_code
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;    // [31:0] value, [47:32] end_position,
                                           // [48] range_error

   string_to_integer_parser_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // parser model state and config copy
   bit [5:0]  base_cfg = BASE_DEC;
   bit        signed_cfg = 1'b1;
   bit [2:0]  phase_q = PH_SPACE;
   bit [5:0]  eff_base = '0;
   bit        neg_q = 1'b0;
   bit [31:0] acc_q = '0;
   bit        ovf_q = 1'b0;
   bit [15:0] pos_q = '0;
   bit [15:0] digits_end_q = '0;

   parse_result_type pending_results[$];
   bit               typed_valid = 1'b0;
   parse_result_type typed_want;

   bit idle_on = 1'b1;
   bit rsp_hold_req = 1'b0;
   int hold_left = 0;
   int stall_left = 0;
   int mismatches = 0;
   int results_checked = 0;
   int chars_sent = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   function automatic bit [6:0] char_digit(input bit [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO);
      if (c >= CH_LA && c <= CH_LZ) return 7'(c - CH_LA) + ALPHA_OFFSET;
      if (c >= CH_UA && c <= CH_UZ) return 7'(c - CH_UA) + ALPHA_OFFSET;
      return NO_DIGIT;
   endfunction

   task automatic note_digit();
      digits_end_q = (pos_q == 16'hFFFF) ? 16'hFFFF : pos_q + 16'd1;
   endtask

   task automatic feed_digit(input bit [7:0] c);
      longint unsigned b;
      longint unsigned d;
      b = (eff_base < 2 || eff_base > BASE_MAX) ? BASE_MAX : eff_base;
      d = char_digit(c);
      if (d >= b) begin
         phase_q = PH_DONE;
         return;
      end
      if (!ovf_q) begin
         if (longint'(acc_q) > (WORD_MASK - d) / b) ovf_q = 1'b1;
         else acc_q = 32'(longint'(acc_q) * b + d);
      end
      note_digit();
   endtask

   task automatic begin_number(input bit [7:0] c);
      bit [5:0] b;
      b = base_cfg;
      if (b == BASE_ONE || b > BASE_MAX) b = BASE_MAX;
      if (c == CH_ZERO && (b == BASE_AUTO || b == BASE_HEX)) begin
         eff_base = b;
         acc_q = '0;
         note_digit();
         phase_q = PH_ZERO;
         return;
      end
      eff_base = (b == BASE_AUTO) ? BASE_DEC : b;
      phase_q = PH_DIGITS;
      feed_digit(c);
   endtask

   // advance the parse by one accepted character, queue the result on a terminator
   task automatic parse_char(input bit [7:0] c);
      parse_result_type r;
      if (c == CH_NUL) begin
         r.end_pos = digits_end_q;
         r.range_err = 1'b0;
         if (signed_cfg) begin
            if (ovf_q) begin
               r.range_err = 1'b1;
               r.value = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (neg_q) begin
               if (acc_q > 32'h8000_0000) begin
                  r.range_err = 1'b1;
                  r.value = 32'h8000_0000;
               end else r.value = -acc_q;
            end else if (acc_q > 32'h7FFF_FFFF) begin
               r.range_err = 1'b1;
               r.value = 32'h7FFF_FFFF;
            end else r.value = acc_q;
         end else if (ovf_q) begin
            r.range_err = 1'b1;
            r.value = 32'hFFFF_FFFF;
         end else r.value = neg_q ? -acc_q : acc_q;
         pending_results.push_back(typed_valid ? typed_want : r);
         typed_valid = 1'b0;
         phase_q = PH_SPACE;
         eff_base = '0;
         neg_q = 1'b0;
         acc_q = '0;
         ovf_q = 1'b0;
         pos_q = '0;
         digits_end_q = '0;
         return;
      end
      case (phase_q)
         PH_SPACE: begin
            if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) begin
            end else if (c == CH_PLUS || c == CH_MINUS) begin
               neg_q = (c == CH_MINUS);
               phase_q = PH_START;
            end else begin
               begin_number(c);
            end
         end
         PH_START: begin_number(c);
         PH_ZERO: begin
            if (c == CH_LX || c == CH_UX) begin
               phase_q = PH_XSEEN;
            end else begin
               eff_base = (eff_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
               phase_q = PH_DIGITS;
               feed_digit(c);
            end
         end
         PH_XSEEN: begin
            eff_base = (eff_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            if (char_digit(c) < 16) begin
               eff_base = BASE_HEX;
               phase_q = PH_DIGITS;
               feed_digit(c);
            end else begin
               phase_q = PH_DONE;
            end
         end
         PH_DIGITS: feed_digit(c);
         default: phase_q = PH_DONE;
      endcase
      if (pos_q != 16'hFFFF) pos_q++;
   endtask

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t mismatch on %s: got %0h, want %0h (result %0d)",
               $time, what, got, want, results_checked);
      mismatches++;
   endtask

   // one character beat; returns at the falling edge after acceptance with valid still high
   task automatic push_char(input bit [7:0] c);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      parse_char(c);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input bit [5:0] base, input bit sgn);
      csr_we    <= 1'b1;
      csr_index <= CSR_BASE;
      csr_wdata <= base;
      @(posedge clock);
      base_cfg = base;
      @(negedge clock);
      csr_index <= CSR_SIGNED;
      csr_wdata <= {5'($urandom), sgn};
      @(posedge clock);
      signed_cfg = sgn;
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // result side: random short stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (rsp_hold_req) begin
         hold_left = HOLD_CYCLES;
         rsp_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      parse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with nothing pending", rsp_tdata[31:0], 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] != want.value)
               report_mismatch("value", rsp_tdata[31:0], want.value);
            if (rsp_tdata[47:32] != want.end_pos)
               report_mismatch("end_position", rsp_tdata[47:32], want.end_pos);
            if (rsp_tdata[48] != want.range_err)
               report_mismatch("range_error", rsp_tdata[48], want.range_err);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d results pending",
                  quiet_cycles, pending_results.size());
         $display("tb_string_to_integer_parser_unit: FAIL");
         $finish;
      end
   end

   // directed strings; the known rows carry their result typed in
   string case_text [0:NUM_ROWS-1] = '{
      "", "\011\012 -42", "+", "\015\013\014+2147483647", "2147483648",
      "-2147483648", "-2147483649", "99999999999z", "\377 5",
      "4294967295", "4294967296", "-1", "-4294967295",
      "0x1F", "0xg", "-017",
      "0XfF", "0x",
      "019", "0x100000000", "zZ", "Zz", "1012", "-0x80000000",
      "0778", "  ab-c", "+0x"
   };
   case_row_type case_rows [0:NUM_ROWS-1] = '{
      '{BASE_DEC, 1'b1, 1'b1, 32'h0, 16'd0, 1'b0},
      '{BASE_DEC, 1'b1, 1'b1, 32'hFFFF_FFD6, 16'd6, 1'b0},
      '{BASE_DEC, 1'b1, 1'b1, 32'h0, 16'd0, 1'b0},
      '{BASE_DEC, 1'b1, 1'b1, 32'h7FFF_FFFF, 16'd14, 1'b0},
      '{BASE_DEC, 1'b1, 1'b1, 32'h7FFF_FFFF, 16'd10, 1'b1},
      '{BASE_DEC, 1'b1, 1'b1, 32'h8000_0000, 16'd11, 1'b0},
      '{BASE_DEC, 1'b1, 1'b1, 32'h8000_0000, 16'd11, 1'b1},
      '{BASE_DEC, 1'b1, 1'b1, 32'h7FFF_FFFF, 16'd11, 1'b1},
      '{BASE_DEC, 1'b1, 1'b1, 32'h0, 16'd0, 1'b0},
      '{BASE_DEC, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'd10, 1'b0},
      '{BASE_DEC, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'd10, 1'b1},
      '{BASE_DEC, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'd2, 1'b0},
      '{BASE_DEC, 1'b0, 1'b1, 32'h1, 16'd11, 1'b0},
      '{BASE_AUTO, 1'b1, 1'b1, 32'h1F, 16'd4, 1'b0},
      '{BASE_AUTO, 1'b1, 1'b1, 32'h0, 16'd1, 1'b0},
      '{BASE_AUTO, 1'b1, 1'b1, 32'hFFFF_FFF1, 16'd4, 1'b0},
      '{BASE_HEX, 1'b1, 1'b1, 32'hFF, 16'd4, 1'b0},
      '{BASE_HEX, 1'b1, 1'b1, 32'h0, 16'd1, 1'b0},
      '{BASE_AUTO, 1'b1, 1'b1, 32'h1, 16'd2, 1'b0},
      '{BASE_AUTO, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'd11, 1'b1},
      '{BASE_ONE, 1'b0, 1'b1, 32'h50F, 16'd2, 1'b0},
      '{6'd63, 1'b0, 1'b1, 32'h50F, 16'd2, 1'b0},
      '{6'd2, 1'b1, 1'b1, 32'h5, 16'd3, 1'b0},
      '{BASE_AUTO, 1'b1, 1'b1, 32'h8000_0000, 16'd11, 1'b0},
      '{BASE_OCT, 1'b1, 1'b1, 32'h3F, 16'd3, 1'b0},
      '{BASE_MAX, 1'b1, 1'b0, 32'h0, 16'd0, 1'b0},
      '{BASE_AUTO, 1'b1, 1'b0, 32'h0, 16'd0, 1'b0}
   };

   initial begin : stimulus
      bit [7:0] text[$];
      bit [5:0] pick;
      int b;
      int v;
      int ndig;
      int start;
      int quota;
      int phase_no;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         if (case_rows[i].base != base_cfg || case_rows[i].sgn != signed_cfg) begin
            wait_idle();
            set_config(case_rows[i].base, case_rows[i].sgn);
         end
         for (int j = 0; j < case_text[i].len(); j++) push_char(case_text[i][j]);
         typed_valid = case_rows[i].known;
         typed_want.value = case_rows[i].value;
         typed_want.end_pos = case_rows[i].end_pos;
         typed_want.range_err = case_rows[i].range_err;
         push_char(CH_NUL);
      end

      start = chars_sent;
      phase_no = 0;
      while (chars_sent - start < RANDOM_CHARS) begin
         wait_idle();
         case ($urandom_range(0, 7))
            0: pick = BASE_AUTO;
            1: pick = BASE_DEC;
            2: pick = BASE_HEX;
            3: pick = BASE_OCT;
            4: pick = 6'd2;
            5: pick = BASE_MAX;
            6: pick = 6'($urandom_range(37, 63));
            default: pick = 6'($urandom_range(0, 63));
         endcase
         set_config(pick, 1'($urandom_range(0, 1)));
         phase_no++;
         if (chars_sent - start > RANDOM_CHARS - 100) idle_on = 1'b0;
         if (phase_no == 2) begin
            // receiver holds off while short strings pile up terminators
            rsp_hold_req = 1'b1;
            repeat (30) begin
               push_char(CH_ZERO + 8'($urandom_range(0, 9)));
               push_char(CH_NUL);
            end
         end
         quota = chars_sent + 60;
         while (chars_sent < quota) begin
            text.delete();
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
            end else begin
               repeat ($urandom_range(0, 2))
                  text.push_back($urandom_range(0, 1) ? CH_SP : 8'($urandom_range(9, 13)));
               case ($urandom_range(0, 3))
                  0: text.push_back(CH_PLUS);
                  1: text.push_back(CH_MINUS);
                  default: ;
               endcase
               b = base_cfg;
               if (b == BASE_ONE || b > BASE_MAX) b = BASE_MAX;
               if (b == BASE_AUTO || b == BASE_HEX) begin
                  case ($urandom_range(0, 3))
                     0: begin
                        text.push_back(CH_ZERO);
                        text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                        b = BASE_HEX;
                     end
                     1: begin
                        text.push_back(CH_ZERO);
                        b = (b == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                     end
                     default: b = (b == BASE_AUTO) ? BASE_DEC : b;
                  endcase
               end
               ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 14)
                                                  : $urandom_range(1, 4);
               repeat (ndig) begin
                  v = $urandom_range(0, b - 1);
                  if (v < 10) text.push_back(CH_ZERO + 8'(v));
                  else text.push_back(($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10));
               end
               // broken sequence: a stray byte somewhere in the string
               if ($urandom_range(0, 4) == 0)
                  text.insert($urandom_range(0, text.size()), 8'($urandom_range(1, 255)));
            end
            foreach (text[k]) push_char(text[k]);
            push_char(CH_NUL);
         end
      end

      wait_idle();
      $display("run covered %0d characters over %0d register settings, %0d results checked",
               chars_sent, settings_used, results_checked);
      if (mismatches == 0) begin
         $display("tb_string_to_integer_parser_unit: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_string_to_integer_parser_unit: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/stoi_pkg.sv
rtl/core/stoi_step.sv
rtl/core/string_to_integer_parser_unit.sv
tb/tb_string_to_integer_parser_unit.sv
